// File: sv/cpht_pkg.sv
// ----------------------------------------------------------------------------
// cpht_pkg: shared types and constants
// Widths, request and status codes, controller states and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cpht_pkg;

  localparam int Buckets     = 256;
  localparam int PoolEntries = 256;
  localparam int PageBits    = 20;
  localparam int FrameBits   = 16;
  localparam int BktBits     = $clog2(Buckets);
  localparam int NodeBits    = $clog2(PoolEntries);
  localparam int LinkBits    = NodeBits + 1;
  localparam int CountBits   = NodeBits + 1;
  localparam int SizeBits    = 9;
  localparam int DivCnt      = 5;

  localparam logic [LinkBits-1:0] NodeNull = LinkBits'(PoolEntries);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_DIV, S_HEAD, S_INS, S_READ, S_CMP, S_UNLINK, S_DONE
  } state_t;

  typedef struct packed {
    logic load;      // capture the request, start the modulo
    logic div_step;  // BitsPerStep restoring-division steps, one bit each
    logic clr_step;  // clear one bucket head
    logic head_rd;   // read the bucket head
    logic ins;       // write the new node and relink the head
    logic node_rd;   // read the current node
    logic advance;   // move to the next node in the chain
    logic unlink;    // unlink current node and push it to the free stack
    logic hit;       // record a lookup hit
    logic done;      // emit the result
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic full;
    logic cur_null;
    logic match;
    logic walk_last;
    logic [1:0] req;
  } sts_t;

endpackage

// File: sv/cpht_ctrl.sv
// ----------------------------------------------------------------------------
// cpht_ctrl: request sequencer
// Clears the bucket heads after reset, then runs each request through the
// modulo, the head read and an insert or a chain walk; an insert that finds the pool full skips to the result.
// ----------------------------------------------------------------------------
module cpht_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output cpht_pkg::cmd_t cmd,
  input  cpht_pkg::sts_t sts
);
  import cpht_pkg::*;

  state_t state, state_next;
  logic [1:0] status, status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      status <= ST_OK;
    end else begin
      state  <= state_next;
      status <= status_next;
    end
  end

  always_comb begin
    state_next  = state;
    status_next = status;
    cmd         = '0;
    busy        = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_HEAD;
      end
      S_HEAD: begin
        status_next = ST_OK;
        priority case (sts.req)
          REQ_INSERT: begin
            if (sts.full) begin
              status_next = ST_FULL;
              state_next  = S_DONE;
            end else begin
              cmd.head_rd = 1'b1;
              state_next  = S_INS;
            end
          end
          REQ_DELETE, REQ_LOOKUP: begin
            cmd.head_rd = 1'b1;
            status_next = ST_MISS;
            state_next  = S_READ;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_INS: begin
        cmd.ins    = 1'b1;
        state_next = S_DONE;
      end
      S_READ: begin
        if (sts.cur_null) state_next = S_DONE;
        else begin
          cmd.node_rd = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.match) begin
          status_next = ST_OK;
          if (sts.req == REQ_LOOKUP) begin
            cmd.hit    = 1'b1;
            state_next = S_DONE;
          end else state_next = S_UNLINK;
        end else if (sts.walk_last) state_next = S_DONE;
        else begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.done   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    cmd.status = status;
  end

endmodule

// File: sv/cpht_dp.sv
// ----------------------------------------------------------------------------
// cpht_dp: table datapath
// Holds the bucket heads, the node pool, the free stack and an iterative
// restoring-division modulo unit.
// ----------------------------------------------------------------------------
module cpht_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cpht_pkg::SizeBits-1:0]    cfg_data,
  input  logic [1:0]                       req_type,
  input  logic [cpht_pkg::PageBits-1:0]    page_number,
  input  logic [cpht_pkg::FrameBits-1:0]   frame_number,
  input  cpht_pkg::cmd_t                   cmd,
  output cpht_pkg::sts_t                   sts,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [cpht_pkg::FrameBits-1:0]   frame_number_out
);
  import cpht_pkg::*;

  localparam int RemBits = SizeBits + 1;
  localparam int BitsPerStep = (PageBits + DivCnt - 1) / DivCnt;
  localparam int DivCntBits = $clog2(DivCnt + 1);

  logic [SizeBits-1:0]  table_size;
  logic [1:0]           req;
  logic [PageBits-1:0]  page, quo;
  logic [FrameBits-1:0] frame;
  logic [SizeBits-1:0]  divisor;
  logic [RemBits-1:0]   rem;
  logic [DivCntBits-1:0] div_cnt;
  logic [BktBits-1:0]   clr_idx;
  logic [CountBits-1:0] free_count, walk_cnt;
  logic [LinkBits-1:0]  cur, prev, cur_next;
  logic [PageBits-1:0]  cur_page;
  logic [FrameBits-1:0] cur_frame;

  logic [LinkBits-1:0]  bucket_head [Buckets];
  logic [PageBits-1:0]  node_page   [PoolEntries];
  logic [FrameBits-1:0] node_frame  [PoolEntries];
  logic [LinkBits-1:0]  node_next   [PoolEntries];
  logic [NodeBits-1:0]  free_top;
  logic [BktBits-1:0]   bucket;

  assign bucket = rem[BktBits-1:0];

  // BitsPerStep restoring-division steps per div_step, one bit each.
  logic [RemBits-1:0]  r_c [BitsPerStep+1];
  logic [PageBits-1:0] q_c [BitsPerStep+1];
  always_comb begin
    r_c[0] = rem;
    q_c[0] = quo;
    for (int i = 0; i < BitsPerStep; i++) begin
      logic [RemBits:0] t;
      t = {r_c[i], q_c[i][PageBits-1]};
      q_c[i+1] = {q_c[i][PageBits-2:0], 1'b0};
      if (t >= {2'b00, divisor}) r_c[i+1] = RemBits'(t - {2'b00, divisor});
      else r_c[i+1] = RemBits'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) table_size <= SizeBits'(Buckets);
    else if (cfg_we) table_size <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      free_count <= CountBits'(PoolEntries);
      done       <= 1'b0;
    end else begin
      done <= cmd.done;
      if (cmd.clr_step) clr_idx <= clr_idx + 1'b1;
      if (cmd.ins) free_count <= free_count - 1'b1;
      if (cmd.unlink && free_count < CountBits'(PoolEntries))
        free_count <= free_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= req_type;
      page  <= page_number;
      frame <= frame_number;
      if (table_size == '0) divisor <= SizeBits'(1);
      else if (table_size > SizeBits'(Buckets)) divisor <= SizeBits'(Buckets);
      else divisor <= table_size;
      quo     <= page_number;
      rem     <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem     <= r_c[BitsPerStep];
      quo     <= q_c[BitsPerStep];
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.head_rd) begin
      cur      <= bucket_head[bucket];
      prev     <= NodeNull;
      walk_cnt <= '0;
    end
    if (cmd.node_rd) begin
      cur_page  <= node_page[cur[NodeBits-1:0]];
      cur_frame <= node_frame[cur[NodeBits-1:0]];
      cur_next  <= node_next[cur[NodeBits-1:0]];
    end
    if (cmd.advance) begin
      prev     <= cur;
      cur      <= cur_next;
      walk_cnt <= walk_cnt + 1'b1;
    end
    if (cmd.load) frame_number_out <= '0;
    else if (cmd.hit) frame_number_out <= cur_frame;
    if (cmd.done) status <= cmd.status;
  end

  // Bucket heads: one write port, one read port. An insert links the new
  // node in front of the head that was read into cur the cycle before.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) bucket_head[clr_idx] <= NodeNull;
    else if (cmd.ins) bucket_head[bucket] <= {1'b0, free_top};
    else if (cmd.unlink && prev == NodeNull) bucket_head[bucket] <= cur_next;
  end

  // Node pool.
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      node_page[free_top]  <= page;
      node_frame[free_top] <= frame;
      node_next[free_top]  <= cur;
    end else if (cmd.unlink && prev != NodeNull) begin
      node_next[prev[NodeBits-1:0]] <= cur_next;
    end
  end

  // Free stack: a slot that was never pushed holds its reset entry, index
  // PoolEntries-1-slot, so one written flag per slot stands in for a clear.
  // The top of stack is read every cycle with registered data.
  logic [PoolEntries-1:0] fs_written;
  logic [NodeBits-1:0]    fs_mem [PoolEntries];
  logic [NodeBits-1:0]    fs_raddr, fs_rd, fs_dflt;
  logic                   fs_hit;

  assign fs_raddr = NodeBits'(free_count - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) fs_written <= '0;
    else if (cmd.unlink && free_count < CountBits'(PoolEntries))
      fs_written[NodeBits'(free_count)] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.unlink && free_count < CountBits'(PoolEntries))
      fs_mem[NodeBits'(free_count)] <= cur[NodeBits-1:0];
    fs_rd   <= fs_mem[fs_raddr];
    fs_hit  <= fs_written[fs_raddr];
    fs_dflt <= NodeBits'(PoolEntries - 1) - fs_raddr;
  end

  assign free_top = fs_hit ? fs_rd : fs_dflt;

  assign sts.clr_last  = (clr_idx == BktBits'(Buckets - 1));
  assign sts.div_last  = (div_cnt == DivCntBits'(DivCnt - 1));
  assign sts.full      = (free_count == '0);
  assign sts.cur_null  = cur[NodeBits];
  assign sts.match     = (cur_page == page);
  assign sts.walk_last = (walk_cnt == CountBits'(PoolEntries - 1));
  assign sts.req       = req;

endmodule

// File: sv/chained_page_hash_table_unit.sv
// ----------------------------------------------------------------------------
// chained_page_hash_table_unit: hashed page table with chained buckets
// Maps page numbers to frame numbers through a bounded node pool.
// ----------------------------------------------------------------------------
// After reset the unit clears every bucket head, with busy high. A request
// is a transfer at a clock edge where start is high and busy is low; exactly
// one result follows, shown for one cycle with done high, and the receiver
// cannot stall it. An insert or a miss in an empty bucket runs the modulo
// unit and the head read, and an insert then writes the node; a delete or
// lookup walks the chain, each node one memory read and compare, and a
// delete that hits then unlinks the node.
// table_size may be written only while busy is low.
module chained_page_hash_table_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            table_size_we,
  input  logic [cpht_pkg::SizeBits-1:0]   table_size,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      req_type,
  input  logic [cpht_pkg::PageBits-1:0]   page_number,
  input  logic [cpht_pkg::FrameBits-1:0]  frame_number,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [cpht_pkg::FrameBits-1:0]  frame_number_out
);
  import cpht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences the request; the datapath holds all storage.
  cpht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  cpht_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (table_size_we),
    .cfg_data         (table_size),
    .req_type         (req_type),
    .page_number      (page_number),
    .frame_number     (frame_number),
    .cmd              (cmd),
    .sts              (sts),
    .done             (done),
    .status           (status),
    .frame_number_out (frame_number_out)
  );

endmodule
